// ===== sv/ptna_pkg.sv =====
// ----------------------------------------------------------------------------
// ptna_pkg
// Shared constants, codes and controller/datapath interface types for the
// page table node allocator.
// ----------------------------------------------------------------------------
package ptna_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NODE_BYTES = 4096;
   localparam int MAX_BATCH  = 8;

   localparam int NODE_SHIFT = $clog2(NODE_BYTES);
   localparam int IDX_W      = $clog2(MAX_NODES) + 1;   // holds MAX_NODES itself
   localparam int LINK_AW    = $clog2(MAX_NODES);
   localparam int CNT_W      = 4;
   localparam int SLOT_W     = 3;
   localparam int ADDR_W     = 64;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 64;

   localparam logic [IDX_W-1:0] LIST_EMPTY    = '1;
   localparam logic [IDX_W-1:0] MAX_NODES_IDX = IDX_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] MAX_BATCH_CNT = CNT_W'(MAX_BATCH);

   // request kinds
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_ALLOC    = 2'd0;
   localparam logic [STAT_W-1:0] ST_DONE     = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd3;

   // register indexes
   localparam logic REG_AREA_START = 1'b0;
   localparam logic REG_NODE_COUNT = 1'b1;

   typedef struct packed {
      logic              load;        // capture request beat
      logic              batch_init;  // slot to zero, clear flush mark
      logic              flush;       // empty list, top back to node one
      logic              restart;     // batch restarts: slot zero, set mark
      logic              rd_link;     // read next link of list head
      logic              take_bump;   // emit bump node, advance top
      logic              take_pop;    // emit head node, head takes link
      logic              calc_off;    // register offset from area start
      logic              push;        // link freed node in as new head
      logic              emit;        // emit a status-only result
      logic [STAT_W-1:0] emit_code;
   } ptna_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             oversize;
      logic             head_valid;
      logic             bump_ok;
      logic             batch_last;
      logic             free_bad;
      logic             out_ready;
   } ptna_stat_type;

endpackage

// ===== sv/ptna_ram.sv =====
// ----------------------------------------------------------------------------
// ptna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ptna_csr.sv =====
// ----------------------------------------------------------------------------
// ptna_csr
// Configuration registers: area start address and node count.
// ----------------------------------------------------------------------------
module ptna_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ptna_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ptna_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ptna_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [ptna_pkg::ADDR_W-1:0]   area_start,
   output logic [ptna_pkg::IDX_W-1:0]    node_count
);
   import ptna_pkg::*;

   logic [ADDR_W-1:0] area_start_ff, area_start_in;
   logic [IDX_W-1:0]  node_count_ff, node_count_in;
   logic              wr_en;
   logic              reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel = csr_paddr[3];

   always_comb begin
      area_start_in = area_start_ff;
      node_count_in = node_count_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_AREA_START: area_start_in = csr_pwdata;
            REG_NODE_COUNT: node_count_in = csr_pwdata[IDX_W-1:0];
            default:        area_start_in = area_start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff <= '0;
         node_count_ff <= MAX_NODES_IDX;
      end else begin
         area_start_ff <= area_start_in;
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_AREA_START: csr_prdata = area_start_ff;
         REG_NODE_COUNT: csr_prdata = CSR_DW'(node_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign area_start = area_start_ff;
   assign node_count = node_count_ff;

endmodule

// ===== sv/ptna_dp.sv =====
// ----------------------------------------------------------------------------
// ptna_dp
// Allocator datapath: request capture, free-list head and bump pointer,
// next-link memory, free address check and the result output register.
// ----------------------------------------------------------------------------
module ptna_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ptna_pkg::ptna_cmd_type            ctl,
   output ptna_pkg::ptna_stat_type           sts,
   input  logic [ptna_pkg::ADDR_W-1:0]       area_start,
   input  logic [ptna_pkg::IDX_W-1:0]        node_count,
   input  logic [ptna_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [ptna_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptna_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ptna_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);
   import ptna_pkg::*;

   localparam int OFF_HI = NODE_SHIFT + IDX_W;

   logic [CMD_W-1:0]  cmd_ff,   cmd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [IDX_W-1:0]  head_ff,  head_in;
   logic [IDX_W-1:0]  bump_ff,  bump_in;
   logic [SLOT_W-1:0] slot_ff,  slot_in;
   logic              mark_ff,  mark_in;
   logic [ADDR_W-1:0] off_ff,   off_in;
   logic              below_ff, below_in;

   logic              ovalid_ff, ovalid_in;
   logic [ADDR_W-1:0] oaddr_ff,  oaddr_in;
   logic [SLOT_W-1:0] oslot_ff,  oslot_in;
   logic              ofl_ff,    ofl_in;
   logic [STAT_W-1:0] ostat_ff,  ostat_in;
   logic              olast_ff,  olast_in;

   logic [IDX_W-1:0]  limit;
   logic [IDX_W-1:0]  cap;
   logic [IDX_W-1:0]  free_idx;
   logic [IDX_W-1:0]  link_rdata;
   logic [IDX_W-1:0]  node_idx;
   logic [ADDR_W-1:0] node_addr;
   logic              out_ready;
   logic              batch_last;

   assign limit = (node_count < MAX_NODES_IDX) ? node_count : MAX_NODES_IDX;
   assign cap   = (limit > IDX_W'(1)) ? limit - IDX_W'(1) : '0;

   assign free_idx   = off_ff[OFF_HI-1:NODE_SHIFT];
   assign out_ready  = !ovalid_ff || rsp_tready;
   assign batch_last = (CNT_W'(slot_ff) + CNT_W'(1)) == count_ff;

   // popped node is the current head, otherwise the bump top
   assign node_idx  = ctl.take_pop ? head_ff : bump_ff;
   assign node_addr = area_start + (ADDR_W'(node_idx) << NODE_SHIFT);

   ptna_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_NODES)
   ) u_link_ram (
      .clock (clock),
      .we    (ctl.push),
      .waddr (free_idx[LINK_AW-1:0]),
      .wdata (head_ff),
      .re    (ctl.rd_link),
      .raddr (head_ff[LINK_AW-1:0]),
      .rdata (link_rdata)
   );

   always_comb begin
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      faddr_in  = faddr_ff;
      head_in   = head_ff;
      bump_in   = bump_ff;
      slot_in   = slot_ff;
      mark_in   = mark_ff;
      off_in    = off_ff;
      below_in  = below_ff;
      ovalid_in = ovalid_ff;
      oaddr_in  = oaddr_ff;
      oslot_in  = oslot_ff;
      ofl_in    = ofl_ff;
      ostat_in  = ostat_ff;
      olast_in  = olast_ff;

      if (ctl.load) begin
         cmd_in   = req_tuser[CMD_W-1:0];
         count_in = req_tdata[CNT_W-1:0];
         faddr_in = req_tdata[CNT_W +: ADDR_W];
      end
      if (ctl.calc_off) begin
         off_in   = faddr_ff - area_start;
         below_in = faddr_ff < area_start;
      end
      if (ctl.batch_init) begin
         slot_in = '0;
         mark_in = 1'b0;
      end
      if (ctl.flush) begin
         head_in = LIST_EMPTY;
         bump_in = IDX_W'(1);
      end
      if (ctl.restart) begin
         slot_in = '0;
         mark_in = 1'b1;
      end
      if (ctl.push) begin
         head_in = free_idx;
      end

      // drop the beat once taken
      if (rsp_tready) begin
         ovalid_in = 1'b0;
      end

      if (ctl.take_bump || ctl.take_pop) begin
         ovalid_in = 1'b1;
         oaddr_in  = node_addr;
         oslot_in  = slot_ff;
         ofl_in    = mark_ff;
         ostat_in  = ST_ALLOC;
         olast_in  = batch_last;
         slot_in   = slot_ff + SLOT_W'(1);
         mark_in   = 1'b0;
         if (ctl.take_pop) begin
            head_in = link_rdata;
         end else begin
            bump_in = bump_ff + IDX_W'(1);
         end
      end else if (ctl.emit) begin
         ovalid_in = 1'b1;
         oaddr_in  = '0;
         oslot_in  = '0;
         ofl_in    = 1'b0;
         ostat_in  = ctl.emit_code;
         olast_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= LIST_EMPTY;
         bump_ff   <= IDX_W'(1);
         slot_ff   <= '0;
         mark_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         bump_ff   <= bump_in;
         slot_ff   <= slot_in;
         mark_ff   <= mark_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
      faddr_ff <= faddr_in;
      off_ff   <= off_in;
      below_ff <= below_in;
      oaddr_ff <= oaddr_in;
      oslot_ff <= oslot_in;
      ofl_ff   <= ofl_in;
      ostat_ff <= ostat_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.count_zero = count_ff == '0;
      sts.oversize   = (count_ff > MAX_BATCH_CNT) || (IDX_W'(count_ff) > cap);
      sts.head_valid = head_ff < MAX_NODES_IDX;
      sts.bump_ok    = bump_ff < limit;
      sts.batch_last = batch_last;
      sts.out_ready  = out_ready;
      // below the area, misaligned, node zero, or at or past the limit
      sts.free_bad   = below_ff
                     || (off_ff[NODE_SHIFT-1:0] != '0)
                     || (off_ff[ADDR_W-1:OFF_HI] != '0)
                     || (free_idx == '0)
                     || (free_idx >= limit);
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - SLOT_W){1'b0}}, oslot_ff, oaddr_ff};
   assign rsp_tuser  = {ostat_ff, ofl_ff};
   assign rsp_tlast  = olast_ff;

endmodule

// ===== sv/ptna_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptna_ctrl
// Allocator controller: decodes each request and sequences batch pops,
// bumps, mid-batch flushes, frees and flushes through the datapath.
// ----------------------------------------------------------------------------
module ptna_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output ptna_pkg::ptna_cmd_type  ctl,
   input  ptna_pkg::ptna_stat_type sts
);
   import ptna_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_FREE_CHK = 3'd2;
   localparam logic [2:0] S_NODE     = 3'd3;
   localparam logic [2:0] S_POP      = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.cmd)
               CMD_ALLOC: begin
                  if (sts.count_zero) begin
                     state_in = S_IDLE;
                  end else if (sts.oversize) begin
                     if (sts.out_ready) begin
                        ctl.emit      = 1'b1;
                        ctl.emit_code = ST_OVERSIZE;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     ctl.batch_init = 1'b1;
                     state_in       = S_NODE;
                  end
               end
               CMD_FREE: begin
                  ctl.calc_off = 1'b1;
                  state_in     = S_FREE_CHK;
               end
               CMD_FLUSH: begin
                  if (sts.out_ready) begin
                     ctl.flush     = 1'b1;
                     ctl.emit      = 1'b1;
                     ctl.emit_code = ST_DONE;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FREE_CHK: begin
            if (sts.out_ready) begin
               ctl.emit = 1'b1;
               if (sts.free_bad) begin
                  ctl.emit_code = ST_BAD_ADDR;
               end else begin
                  ctl.push      = 1'b1;
                  ctl.emit_code = ST_DONE;
               end
               state_in = S_IDLE;
            end
         end
         S_NODE: begin
            if (sts.head_valid) begin
               ctl.rd_link = 1'b1;
               state_in    = S_POP;
            end else if (sts.bump_ok) begin
               if (sts.out_ready) begin
                  ctl.take_bump = 1'b1;
                  if (sts.batch_last) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               // area exhausted: flush and restart the batch
               ctl.flush   = 1'b1;
               ctl.restart = 1'b1;
            end
         end
         S_POP: begin
            if (sts.out_ready) begin
               ctl.take_pop = 1'b1;
               state_in     = sts.batch_last ? S_IDLE : S_NODE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/page_table_node_allocator.sv =====
// ----------------------------------------------------------------------------
// page_table_node_allocator
// Fixed-size node allocator with a LIFO free list and a bump pointer.
// ----------------------------------------------------------------------------
// One request at a time is taken; req_tready is high only while the block is
// idle. Every request is captured in the idle state and decoded in the decode
// state before anything else happens. An allocate then cuts each node from
// the bump pointer in the node state, or pops it from the free list through
// the node and pop states (the next link is read through the registered port
// of the link memory before the head moves). If the area runs dry mid-batch,
// the node state flushes it and the batch starts over from slot zero, so its
// nodes are counted again. A free passes through capture, offset, then check
// and push, and a flush through capture, then flush. Results leave through a
// single output register, so a stalled rsp_tready holds the sequencer at its
// next result. The link memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module page_table_node_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = alloc_count[3:0], free_address[67:4], zero pad
   //          tuser = cmd[1:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ptna_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [ptna_pkg::REQ_USER_W-1:0]   req_tuser,
   // result: tdata = node_address[63:0], slot[66:64], zero pad
   //         tuser = flushed[0], status[2:1]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptna_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ptna_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptna_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [ptna_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [ptna_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import ptna_pkg::*;

   ptna_cmd_type      ctl;
   ptna_stat_type     sts;
   logic [ADDR_W-1:0] area_start;
   logic [IDX_W-1:0]  node_count;

   ptna_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .area_start  (area_start),
      .node_count  (node_count)
   );

   ptna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ctl        (ctl),
      .sts        (sts)
   );

   ptna_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .area_start (area_start),
      .node_count (node_count),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the page table node allocator against a behavioral allocator: free
// list pops, bump allocation, mid-batch flush and restart, oversized batches,
// bad free addresses and flushes, across several area settings, with bursty
// request traffic and a result receiver that stalls.
// ----------------------------------------------------------------------------
module testbench;
   import ptna_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] addr;
   } request_type;

   typedef struct packed {
      logic [ADDR_W-1:0] node_address;
      logic [SLOT_W-1:0] slot;
      logic              flushed;
      logic [STAT_W-1:0] status;
      logic              last;
   } reply_type;

   typedef enum {STREAM_FREE, STREAM_COIN, STREAM_SPARSE, STREAM_SQUARE} stall_style_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]       csr_paddr = '0;
   logic [CSR_DW-1:0]       csr_pwdata = '0;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   // allocator state as the block should hold it
   logic [ADDR_W-1:0] area_base = '0;
   logic [10:0]       node_total = 11'd1024;
   logic [IDX_W-1:0]  list_head = LIST_EMPTY;
   logic [IDX_W-1:0]  bump_top = 1;
   logic [IDX_W-1:0]  next_link [0:MAX_NODES-1];

   request_type     request_backlog[$];
   reply_type       awaited_replies[$];
   request_type     in_flight;
   bit              req_taken = 0;
   int unsigned     gap_left = 0;
   int unsigned     burst_left = 1;
   int unsigned     stall_window = 0;
   stall_style_type stall_mode = STREAM_FREE;
   int              errors = 0;

   page_table_node_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned limit_now();
      return (node_total < MAX_NODES) ? node_total : MAX_NODES;
   endfunction

   // Work out the results of one accepted request and update the area state.
   task automatic allocator_step(input request_type r);
      reply_type         batch[$];
      reply_type         rep;
      int unsigned       lim, cap, i, idx;
      logic              mark, restarted;
      logic [ADDR_W-1:0] off, nidx;
      lim = limit_now();
      cap = (lim > 1) ? lim - 1 : 0;
      rep = '0;
      rep.last = 1'b1;
      case (r.cmd)
         CMD_ALLOC: begin
            if (r.count == 0) return;
            if (r.count > MAX_BATCH || r.count > cap) begin
               rep.status = ST_OVERSIZE;
               awaited_replies.push_back(rep);
               return;
            end
            i = 0;
            mark = 1'b0;
            restarted = 1'b0;
            while (i < r.count) begin
               if (list_head != LIST_EMPTY && list_head < MAX_NODES) begin
                  idx = 32'(list_head);
                  list_head = next_link[idx];
               end else if (bump_top < lim) begin
                  idx = 32'(bump_top);
                  bump_top = bump_top + 1'b1;
               end else begin
                  if (restarted) break;
                  // area ran dry: flush and start the batch over
                  list_head = LIST_EMPTY;
                  bump_top = 1;
                  restarted = 1'b1;
                  mark = 1'b1;
                  i = 0;
                  continue;
               end
               rep.node_address = area_base + (ADDR_W'(idx) << NODE_SHIFT);
               rep.slot = SLOT_W'(i);
               rep.flushed = mark;
               rep.status = ST_ALLOC;
               rep.last = 1'b0;
               batch.push_back(rep);
               mark = 1'b0;
               i++;
            end
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[k]) awaited_replies.push_back(batch[k]);
         end
         CMD_FREE: begin
            off = r.addr - area_base;
            nidx = off >> NODE_SHIFT;
            if (r.addr < area_base || off[NODE_SHIFT-1:0] != 0 || nidx == 0 || nidx >= lim) begin
               rep.status = ST_BAD_ADDR;
            end else begin
               next_link[nidx[LINK_AW-1:0]] = list_head;
               list_head = nidx[IDX_W-1:0];
               rep.status = ST_DONE;
            end
            awaited_replies.push_back(rep);
         end
         CMD_FLUSH: begin
            list_head = LIST_EMPTY;
            bump_top = 1;
            rep.status = ST_DONE;
            awaited_replies.push_back(rep);
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed traffic for the current area, some broken requests.
   function automatic request_type random_request();
      request_type r;
      int unsigned roll, lim, top_count;
      lim = limit_now();
      top_count = (lim - 1 < MAX_BATCH) ? lim - 1 : MAX_BATCH;
      r.cmd = CMD_ALLOC;
      r.count = '0;
      r.addr = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 48) begin
         if (roll < 42) r.count = CNT_W'($urandom_range(1, top_count));
         else r.count = CNT_W'($urandom_range(0, 15));
      end else if (roll < 85) begin
         r.cmd = CMD_FREE;
         if (roll < 74) begin
            r.addr = area_base + (ADDR_W'($urandom_range(1, lim - 1)) << NODE_SHIFT);
         end else begin
            case ($urandom_range(0, 4))
               0: ;
               1: r.addr = area_base;
               2: r.addr = area_base + (ADDR_W'(lim) << NODE_SHIFT);
               3: r.addr = area_base + (ADDR_W'($urandom_range(1, lim - 1)) << NODE_SHIFT)
                           + ADDR_W'($urandom_range(1, NODE_BYTES - 1));
               default: r.addr = area_base - ADDR_W'($urandom_range(1, 3 * NODE_BYTES));
            endcase
         end
      end else if (roll < 95) begin
         r.cmd = CMD_FLUSH;
      end else begin
         r.cmd = CMD_UNUSED;
      end
      return r;
   endfunction

   task automatic queue_request(input logic [CMD_W-1:0] cmd, input int count,
                                input logic [ADDR_W-1:0] addr);
      request_backlog.push_back('{cmd, CNT_W'(count), addr});
   endtask

   // Hold until every request is taken and every result is in, then let the
   // block finish any request that makes no result.
   task automatic settle();
      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic program_area(input logic [ADDR_W-1:0] base, input int count);
      settle();
      csr_write({REG_AREA_START, 3'b000}, base);
      csr_write({REG_NODE_COUNT, 3'b000}, CSR_DW'(count));
      area_base = base;
      node_total = 11'(count);
   endtask

   task automatic random_phase(input logic [ADDR_W-1:0] base, input int count, input int items);
      request_type r;
      program_area(base, count);
      for (int n = 0; n < items; ) begin
         r = random_request();
         request_backlog.push_back(r);
         if (!(r.cmd == CMD_UNUSED || (r.cmd == CMD_ALLOC && r.count == 0))) n++;
      end
   endtask

   // sender: bursts of beats with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            in_flight = request_backlog.pop_front();
            req_tdata <= {4'b0, in_flight.addr, in_flight.count};
            req_tuser <= in_flight.cmd;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall style changes from window to window
   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_mode = stall_style_type'($urandom_range(0, 3));
         stall_window = $urandom_range(8, 80);
      end else begin
         stall_window--;
      end
      case (stall_mode)
         STREAM_FREE:   rsp_tready <= 1'b1;
         STREAM_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         STREAM_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
         default:       rsp_tready <= stall_window[3];
      endcase
   end

   always @(posedge clock) begin
      reply_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0], rsp_tdata[66:64], rsp_tuser[0], rsp_tuser[2:1], rsp_tlast};
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected result addr=%h slot=%0d flushed=%0b status=%0d last=%0b",
                     $time, got.node_address, got.slot, got.flushed, got.status, got.last);
            errors++;
         end else begin
            want = awaited_replies.pop_front();
            if (got !== want) begin
               $display("%0t: expected addr=%h slot=%0d flushed=%0b status=%0d last=%0b",
                        $time, want.node_address, want.slot, want.flushed, want.status,
                        want.last,
                        ", got addr=%h slot=%0d flushed=%0b status=%0d last=%0b",
                        got.node_address, got.slot, got.flushed, got.status, got.last);
               errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         allocator_step(in_flight);
         req_taken = 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full area at base zero: sizes, bad frees, double free, unknown command
      program_area('0, MAX_NODES);
      queue_request(CMD_ALLOC, 1, '0);
      queue_request(CMD_ALLOC, MAX_BATCH, '0);
      queue_request(CMD_ALLOC, 0, '0);
      queue_request(CMD_ALLOC, MAX_BATCH + 1, '0);
      queue_request(CMD_ALLOC, 15, '0);
      queue_request(CMD_FREE, 0, 64'd3 << NODE_SHIFT);
      queue_request(CMD_FREE, 0, 64'd3 << NODE_SHIFT);
      queue_request(CMD_ALLOC, 3, '0);
      queue_request(CMD_FREE, 0, '0);
      queue_request(CMD_FREE, 0, (64'd1 << NODE_SHIFT) + 64'd1);
      queue_request(CMD_FREE, 0, 64'(MAX_NODES) << NODE_SHIFT);
      queue_request(CMD_FREE, 0, '1);
      queue_request(CMD_FREE, 0, 64'h8000_0000_0000_0000);
      queue_request(CMD_UNUSED, 0, '0);
      queue_request(CMD_FLUSH, 0, '0);

      // area at the top of the address space, three nodes: wrap and restart
      program_area(64'hFFFF_FFFF_FFFF_E000, 3);
      queue_request(CMD_ALLOC, 2, '0);
      queue_request(CMD_ALLOC, 1, '0);
      queue_request(CMD_ALLOC, 3, '0);
      queue_request(CMD_FREE, 0, '0);
      queue_request(CMD_FREE, 0, 64'hFFFF_FFFF_FFFF_F000);
      queue_request(CMD_ALLOC, 2, '0);

      // nine nodes: a full batch restarting late gives the most results
      program_area({$urandom, $urandom} & ~64'(NODE_BYTES - 1), 9);
      queue_request(CMD_ALLOC, 1, '0);
      queue_request(CMD_ALLOC, MAX_BATCH, '0);

      random_phase({$urandom, $urandom} & ~64'(NODE_BYTES - 1), $urandom_range(2, 16), 15);
      random_phase('1, MAX_NODES, 15);
      random_phase('0, $urandom_range(512, 1023), 15);
      random_phase({$urandom, $urandom}, 2, 15);
      random_phase({$urandom, $urandom} & ~64'(NODE_BYTES - 1), 9, 15);

      settle();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ptna_pkg.sv
sv/ptna_ram.sv
sv/ptna_csr.sv
sv/ptna_dp.sv
sv/ptna_ctrl.sv
sv/page_table_node_allocator.sv
tb/testbench.sv
